/* sv/stpa_pkg.sv */
// ============================================================================
// stpa_pkg: shared types and codes for the sprite tile and palette allocator
// Request and result payloads, command and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package stpa_pkg;

	// Request commands.
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_UNLOAD = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SKIP    = 3'd1;
	localparam logic [2:0] ST_NOPAL   = 3'd2;
	localparam logic [2:0] ST_NOTILE  = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic       sprite_loaded;
		logic       palette_preloaded;
		logic [3:0] palette_slot;
		logic [6:0] tile_count;
		logic [9:0] start_tile;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] palette_out;
		logic       palette_new;
		logic [9:0] tile_out;
		logic       palette_released;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       wipe;
		logic       refs_clear;
		logic       pal_dec;
		logic       pscan;
		logic       pal_inc;
		logic       tscan_init;
		logic       tscan;
		logic       mark;
		logic       free_init;
		logic       free;
		logic       finish;
		logic [2:0] code;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wipe_last;
		logic cmd_load;
		logic cmd_unload;
		logic cmd_clear;
		logic loaded;
		logic pre;
		logic pslot_ok;
		logic start_ok;
		logic run_ok;
		logic pal_hit;
		logic pal_last;
		logic run_found;
		logic run_fail;
		logic mark_last;
		logic free_done;
	} sts_t;

endpackage

`default_nettype wire

/* sv/stpa_ctrl.sv */
// ============================================================================
// stpa_ctrl: sequencing state machine of the allocator
// Walks each request through dispatch, palette scan, run search, marking and
// freeing, and tells the datapath when to report the result.
// ============================================================================
`default_nettype none

module stpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire stpa_pkg::sts_t sts,
	output stpa_pkg::ctl_t     ctl,
	output logic               busy
);
	import stpa_pkg::*;

	typedef enum logic [7:0] {
		S_CLR   = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DISP  = 8'b0000_0100,
		S_PSCAN = 8'b0000_1000,
		S_PINC  = 8'b0001_0000,
		S_TSCAN = 8'b0010_0000,
		S_TMARK = 8'b0100_0000,
		S_FREE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		case (state_q)
			S_CLR: begin
				ctl.wipe = 1'b1;
				if (sts.wipe_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_nx    = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.cmd_load && !sts.loaded) begin
					if (!sts.pre) begin
						ctl.pscan = 1'b1;
						state_nx  = S_PSCAN;
					end else if (sts.pslot_ok) begin
						state_nx = S_PINC;
					end else begin
						ctl.finish = 1'b1;
						ctl.code   = ST_NOPAL;
						state_nx   = S_IDLE;
					end
				end else if (sts.cmd_unload && sts.loaded) begin
					ctl.pal_dec = sts.pslot_ok;
					if (sts.start_ok) begin
						ctl.free_init = 1'b1;
						state_nx      = S_FREE;
					end else begin
						ctl.finish = 1'b1;
						ctl.code   = ST_OK;
						state_nx   = S_IDLE;
					end
				end else if (sts.cmd_clear) begin
					ctl.refs_clear = 1'b1;
					ctl.finish     = 1'b1;
					ctl.code       = ST_CLEARED;
					state_nx       = S_IDLE;
				end else begin
					ctl.finish = 1'b1;
					ctl.code   = ST_SKIP;
					state_nx   = S_IDLE;
				end
			end
			S_PSCAN: begin
				ctl.pscan = 1'b1;
				if (sts.pal_hit) begin
					state_nx = S_PINC;
				end else if (sts.pal_last) begin
					ctl.finish = 1'b1;
					ctl.code   = ST_NOPAL;
					state_nx   = S_IDLE;
				end
			end
			S_PINC: begin
				ctl.pal_inc = 1'b1;
				if (sts.run_ok) begin
					ctl.tscan_init = 1'b1;
					state_nx       = S_TSCAN;
				end else begin
					ctl.finish = 1'b1;
					ctl.code   = ST_NOTILE;
					state_nx   = S_IDLE;
				end
			end
			S_TSCAN: begin
				ctl.tscan = 1'b1;
				if (sts.run_found) begin
					state_nx = S_TMARK;
				end else if (sts.run_fail) begin
					ctl.finish = 1'b1;
					ctl.code   = ST_NOTILE;
					state_nx   = S_IDLE;
				end
			end
			S_TMARK: begin
				ctl.mark = 1'b1;
				if (sts.mark_last) begin
					ctl.finish = 1'b1;
					ctl.code   = ST_OK;
					state_nx   = S_IDLE;
				end
			end
			S_FREE: begin
				ctl.free = 1'b1;
				if (sts.free_done) begin
					ctl.finish = 1'b1;
					ctl.code   = ST_OK;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/stpa_dpath.sv */
// ============================================================================
// stpa_dpath: datapath of the allocator
// Holds the tile mark memory, the palette reference counts, the scan pointers
// and the result register.
// ============================================================================
`default_nettype none

module stpa_dpath #(
	parameter int TILE_SLOTS    = 1024,
	parameter int PALETTE_SLOTS = 16,
	parameter int MAX_RUN       = 64,
	parameter int REF_BITS      = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stpa_pkg::req_t req,
	input  wire stpa_pkg::ctl_t ctl,
	output stpa_pkg::sts_t      sts,
	output logic                done,
	output stpa_pkg::rsp_t      rsp
);
	import stpa_pkg::*;

	localparam int TW = $clog2(TILE_SLOTS);
	localparam int PW = $clog2(PALETTE_SLOTS);
	// Wide enough for a start tile plus one and for a head plus two run lengths.
	localparam int SW = $clog2(TILE_SLOTS + 1280);

	localparam logic [1:0] MARK_UNUSED = 2'd0;
	localparam logic [1:0] MARK_USED   = 2'd1;
	localparam logic [1:0] MARK_CONT   = 2'd2;

	logic [1:0]          mem [TILE_SLOTS];
	logic [1:0]          rd_q;
	logic                we;
	logic [TW-1:0]       waddr;
	logic [1:0]          wdata;
	logic [TW-1:0]       raddr;

	req_t                req_q;
	logic [REF_BITS-1:0] refs_q [PALETTE_SLOTS];
	logic [PW-1:0]       pal_q;
	logic [PW-1:0]       pscan_q;
	logic [PW-1:0]       pidx;
	logic [REF_BITS-1:0] ref_sel;
	logic                pal_new_q;
	logic                released_q;
	logic [TW-1:0]       wipe_q;
	logic [TW-1:0]       h_q;
	logic [TW-1:0]       a_q;
	logic [TW-1:0]       pa_q;
	logic                pv_q;
	logic [6:0]          k_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic [SW-1:0]       n_w;
	logic [SW-1:0]       h_end;
	logic [SW-1:0]       h_far;
	logic [SW-1:0]       pa_nx;
	logic [SW-1:0]       start_nx;
	logic [SW-1:0]       slots_w;
	logic                hit_used;
	logic                is_load;
	logic                pal_give;

	assign n_w      = SW'(req_q.tile_count);
	assign slots_w  = SW'(TILE_SLOTS);
	assign h_end    = SW'(h_q) + n_w;
	assign h_far    = h_end + n_w;
	assign pa_nx    = SW'(pa_q) + SW'(1);
	assign start_nx = SW'(req_q.start_tile) + SW'(1);
	assign hit_used = pv_q && (rd_q != MARK_UNUSED);

	assign pidx    = ctl.pscan ? pscan_q : pal_q;
	assign ref_sel = refs_q[pidx];

	// Status toward the controller.
	always_comb begin
		sts.wipe_last  = (wipe_q == TW'(TILE_SLOTS - 1));
		sts.cmd_load   = (req_q.cmd == CMD_LOAD);
		sts.cmd_unload = (req_q.cmd == CMD_UNLOAD);
		sts.cmd_clear  = (req_q.cmd == CMD_CLEAR);
		sts.loaded     = req_q.sprite_loaded;
		sts.pre        = req_q.palette_preloaded;
		sts.pslot_ok   = (int'(req_q.palette_slot) < PALETTE_SLOTS);
		sts.start_ok   = (int'(req_q.start_tile) < TILE_SLOTS);
		sts.run_ok     = (req_q.tile_count != 7'd0) && (n_w <= SW'(MAX_RUN))
			&& ((n_w + n_w) <= slots_w);
		sts.pal_hit    = (ref_sel == '0);
		sts.pal_last   = (pscan_q == PW'(PALETTE_SLOTS - 1));
		sts.run_found  = pv_q && (rd_q == MARK_UNUSED) && (pa_nx == h_end);
		sts.run_fail   = hit_used && (h_far > slots_w);
		sts.mark_last  = ((SW'(k_q) + SW'(1)) == n_w);
		sts.free_done  = !pv_q || (rd_q != MARK_CONT) || (pa_nx >= slots_w);
	end

	// Memory port steering.
	always_comb begin
		we    = 1'b0;
		waddr = wipe_q;
		wdata = MARK_UNUSED;
		raddr = a_q;
		if (ctl.wipe) begin
			we = 1'b1;
		end
		if (ctl.mark) begin
			we    = 1'b1;
			waddr = h_q + TW'(k_q);
			wdata = (k_q == 7'd0) ? MARK_USED : MARK_CONT;
		end
		if (ctl.tscan && hit_used) begin
			raddr = TW'(h_end);
		end
		if (ctl.free_init) begin
			we    = 1'b1;
			waddr = TW'(req_q.start_tile);
			raddr = TW'(start_nx);
		end
		if (ctl.free) begin
			we    = pv_q && (rd_q == MARK_CONT);
			waddr = pa_q;
			raddr = TW'(pa_nx);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Reference counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_SLOTS; i++) begin
				refs_q[i] <= '0;
			end
		end else if (ctl.refs_clear) begin
			for (int i = 0; i < PALETTE_SLOTS; i++) begin
				refs_q[i] <= '0;
			end
		end else if (ctl.pal_inc && (ref_sel != '1)) begin
			refs_q[pal_q] <= ref_sel + REF_BITS'(1);
		end else if (ctl.pal_dec && (ref_sel != '0)) begin
			refs_q[pal_q] <= ref_sel - REF_BITS'(1);
		end
	end

	// Clearing pass pointer and result pulse flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctl.wipe) begin
				wipe_q <= wipe_q + TW'(1);
			end
			done_q <= ctl.finish;
		end
	end

	// Request, palette and scan registers.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q      <= req;
			pal_q      <= PW'(req.palette_slot);
			pscan_q    <= '0;
			pal_new_q  <= 1'b0;
			released_q <= 1'b0;
		end
		if (ctl.pscan && !ctl.capture) begin
			if (sts.pal_hit) begin
				pal_q     <= pscan_q;
				pal_new_q <= 1'b1;
			end else begin
				pscan_q <= pscan_q + PW'(1);
			end
		end
		if (ctl.pal_dec) begin
			released_q <= (ref_sel <= REF_BITS'(1));
		end
		if (ctl.tscan_init) begin
			h_q  <= TW'(req_q.tile_count);
			a_q  <= TW'(req_q.tile_count);
			pv_q <= 1'b0;
			k_q  <= '0;
		end
		if (ctl.tscan) begin
			pv_q <= 1'b1;
			if (hit_used) begin
				h_q  <= TW'(h_end);
				a_q  <= TW'(h_end + SW'(1));
				pa_q <= TW'(h_end);
			end else if (!sts.run_found) begin
				pa_q <= a_q;
				a_q  <= a_q + TW'(1);
			end
		end
		if (ctl.mark) begin
			k_q <= k_q + 7'd1;
		end
		if (ctl.free_init) begin
			pa_q <= TW'(start_nx);
			pv_q <= (start_nx < slots_w);
		end
		if (ctl.free) begin
			pa_q <= TW'(pa_nx);
			pv_q <= pv_q && (rd_q == MARK_CONT) && (pa_nx < slots_w);
		end
	end

	// Result register.
	assign is_load  = (req_q.cmd == CMD_LOAD);
	assign pal_give = is_load && ((ctl.code == ST_OK) || (ctl.code == ST_NOTILE));

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q.status           <= ctl.code;
			rsp_q.palette_out      <= pal_give ? 4'(pal_q) : 4'd0;
			rsp_q.palette_new      <= pal_give && pal_new_q;
			rsp_q.tile_out         <= (is_load && (ctl.code == ST_OK)) ? 10'(h_q) : 10'd0;
			rsp_q.palette_released <= released_q || (ctl.pal_dec && (ref_sel <= REF_BITS'(1)));
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

/* sv/sprite_tile_palette_allocator.sv */
// ============================================================================
// sprite_tile_palette_allocator: tile run and palette slot allocator
// Loads reserve an aligned run of tile slots and a counted palette slot;
// unloads free them; a clear drops all palette counts.
// ============================================================================
// A request is taken at a rising edge where start is high and busy is low, and
// exactly one result comes back later as a one-cycle pulse on done with the
// payload on rsp. The receiver cannot hold a result off, so it must take rsp
// in the cycle done is high. Requests are handled one at a time and busy stays
// high until the result has been registered; a new request can be issued in
// the same cycle that done is high. After reset the block sweeps the tile mark
// memory to unused, one entry per cycle, and holds busy high until the sweep
// has ended before it takes its first request.
//
// Steps per request, from accept to done: skip, clear and unknown commands
// finish in dispatch. An unload frees the head and then each continuation
// tile that follows it. A load takes a dispatch step, a palette scan when
// the palette is not given, an increment step, then the run search and the
// marking of each tile of the run. The run search spends a start-up step and
// then reads the tile mark memory, which has one write and one read port, one
// entry per cycle; a used tile sends the read straight to the first tile of
// the next candidate run in the same cycle, and that memory scan sets the
// worst case.
//
// Status codes: ok, skipped, no palette free, no tile space, cleared. The
// palette fields are reported only for a load that got a palette, the tile
// field only for a successful load, and the released flag only for an unload.
`default_nettype none

module sprite_tile_palette_allocator #(
	parameter int TILE_SLOTS    = 1024,
	parameter int PALETTE_SLOTS = 16,
	parameter int MAX_RUN       = 64,
	parameter int REF_BITS      = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire stpa_pkg::req_t req,
	output logic                done,
	output stpa_pkg::rsp_t      rsp
);
	import stpa_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// The controller sequences each request; the datapath owns all storage.
	stpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	stpa_dpath #(
		.TILE_SLOTS    (TILE_SLOTS),
		.PALETTE_SLOTS (PALETTE_SLOTS),
		.MAX_RUN       (MAX_RUN),
		.REF_BITS      (REF_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* sv/stpa_chk.sv */
// ============================================================================
// stpa_chk: port-level checker for the allocator
// Watches the request and result ports over time and is bound to the top.
// ============================================================================
`default_nettype none

module stpa_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire stpa_pkg::rsp_t rsp
);
	import stpa_pkg::*;

	// An accepted request keeps the block busy until its result is out.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// A result only follows work in progress, and the block is free with it.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result pulse without a request in progress");

	// Palette fields are only reported for a load that kept its palette.
	a_pal_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) && (rsp.status != ST_NOTILE)
		|-> (rsp.palette_out == 4'd0) && !rsp.palette_new)
		else $error("palette fields set on a result that gives none");

	// A tile index only comes with a successful request.
	a_tile_field: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> (rsp.tile_out == 10'd0))
		else $error("tile index set on a failed result");

endmodule

bind sprite_tile_palette_allocator stpa_chk u_stpa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
